>>> sv/bics_pkg.sv
// Package for the byte ISA CPU step core: opcodes, request codes, microcode ROM.
package bics_pkg;

  localparam int RegisterCountDefault = 4;
  localparam int MemoryBytesDefault   = 256;

  // Request types
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  // Opcodes
  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_HALT  = 8'd1;
  localparam logic [7:0] OP_LOADI = 8'd2;
  localparam logic [7:0] OP_ADD   = 8'd3;
  localparam logic [7:0] OP_SUB   = 8'd4;
  localparam logic [7:0] OP_JMP   = 8'd5;
  localparam logic [7:0] OP_JZ    = 8'd6;
  localparam logic [7:0] OP_LOAD  = 8'd7;
  localparam logic [7:0] OP_STORE = 8'd8;
  localparam logic [7:0] OP_CMP   = 8'd9;

  // Microcode step addresses
  typedef logic [2:0] uc_step_t;
  localparam uc_step_t UC_FETCH0 = 3'd0;
  localparam uc_step_t UC_FETCH1 = 3'd1;
  localparam uc_step_t UC_FETCH2 = 3'd2;
  localparam uc_step_t UC_DECODE = 3'd3;
  localparam uc_step_t UC_EXEC   = 3'd4;
  localparam uc_step_t UC_LDWB   = 3'd5;
  localparam uc_step_t UC_DONE   = 3'd6;

  // Memory port address source
  typedef enum logic [2:0] {
    UM_NONE = 3'd0,
    UM_PC0  = 3'd1,
    UM_PC1  = 3'd2,
    UM_PC2  = 3'd3,
    UM_DATA = 3'd4
  } uc_mem_e;

  // Jump condition
  typedef enum logic [1:0] {
    UJ_NEVER       = 2'd0,
    UJ_FETCH_FAULT = 2'd1,
    UJ_NOT_LOAD    = 2'd2
  } uc_cond_e;

  typedef struct packed {
    uc_mem_e  mem;
    logic     lat_op;
    logic     lat_a;
    logic     lat_b;
    logic     exec;
    logic     ldwb;
    logic     done;
    uc_cond_e cond;
    uc_step_t jump;
    uc_step_t next;
  } uc_word_t;

  function automatic uc_word_t uc_rom(input uc_step_t step);
    uc_word_t w;
    w = '{mem: UM_NONE, lat_op: 1'b0, lat_a: 1'b0, lat_b: 1'b0, exec: 1'b0,
          ldwb: 1'b0, done: 1'b0, cond: UJ_NEVER, jump: UC_DONE, next: UC_DONE};
    unique case (step)
      UC_FETCH0: begin
        w.mem  = UM_PC0;
        w.cond = UJ_FETCH_FAULT;
        w.next = UC_FETCH1;
      end
      UC_FETCH1: begin
        w.mem    = UM_PC1;
        w.lat_op = 1'b1;
        w.next   = UC_FETCH2;
      end
      UC_FETCH2: begin
        w.mem   = UM_PC2;
        w.lat_a = 1'b1;
        w.next  = UC_DECODE;
      end
      UC_DECODE: begin
        w.lat_b = 1'b1;
        w.next  = UC_EXEC;
      end
      UC_EXEC: begin
        w.mem  = UM_DATA;
        w.exec = 1'b1;
        w.cond = UJ_NOT_LOAD;
        w.next = UC_LDWB;
      end
      UC_LDWB: begin
        w.ldwb = 1'b1;
        w.next = UC_DONE;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Multiple of three by folding base-4 digits (4 is 1 mod 3)
  function automatic logic is_mult3(input logic [7:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
    s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
    return (s2 == 3'd0) || (s2 == 3'd3) || (s2 == 3'd6);
  endfunction

endpackage

>>> sv/byte_isa_cpu_step_core.sv
// Top level of the byte ISA CPU step core: microcoded sequencer and datapath.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  request  | in        | in_valid_i/in_stall_o | req_type_i, address_i, write_data_i
//  result   | out       | out_valid_o/out_stall_i | ok_o, halted_now_o, program_counter_o,
//           |           |                      | zero_flag_out_o, reg0..reg3_value_o
//  config   | in        | cfg_we_i             | cfg_wdata_i (program length)
//
// Steps: an execute request's sequence is set by the single memory port with registered
// read: three fetch reads, a decode step, an execute step (plus a LOAD write-back) and a
// delivery step. An execute refused at fetch (halted, or fetch past the program) goes
// straight from the first fetch step to delivery. Clear and write go straight to delivery.
// Reset: async, active low; the 256 memory valid bits clear at once, so no sweep is needed.
// Stalls: the result waits in the output register; a finished request holds in its
// delivery step until that register frees up. A new request is taken only when idle.

module byte_isa_cpu_step_core #(
  parameter int REGISTER_COUNT = bics_pkg::RegisterCountDefault,
  parameter int MEMORY_BYTES   = bics_pkg::MemoryBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  // request
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] address_i,
  input  logic [7:0] write_data_i,
  // result
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       ok_o,
  output logic       halted_now_o,
  output logic [7:0] program_counter_o,
  output logic       zero_flag_out_o,
  output logic [7:0] reg0_value_o,
  output logic [7:0] reg1_value_o,
  output logic [7:0] reg2_value_o,
  output logic [7:0] reg3_value_o
);

  localparam int AW  = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;
  localparam int RIW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [8:0] MemLen = 9'(MEMORY_BYTES);
  localparam logic [8:0] RegCnt = 9'(REGISTER_COUNT);

  // Architectural state
  logic [8:0] prog_len_q;
  logic [7:0] rf_q [REGISTER_COUNT];
  logic [7:0] pc_q;
  logic       zf_q;
  logic       halt_q;

  // Sequencer and instruction latches
  logic                busy_q;
  bics_pkg::uc_step_t  step_q;
  bics_pkg::uc_word_t  uc;
  logic                ok_q;
  logic [7:0]          op_q, a_q, b_q;
  logic [7:0]          opa_q, opb_q;

  // Memory, its valid bits and read data
  logic [7:0]              mem_q [MEMORY_BYTES];
  logic [MEMORY_BYTES-1:0] vld_q;
  logic [7:0]              rd_q;
  logic                    vld_rd_q;
  logic [7:0]              rdata;

  // Output register
  logic       out_valid_q;
  logic       out_ok_q, out_halt_q, out_zf_q;
  logic [7:0] out_pc_q;
  logic [7:0] out_rf_q [4];
  logic [7:0] rf_view [4];

  logic in_acc;
  logic deliver;
  logic take_jump;

  logic [8:0] len_eff;
  logic [8:0] pc_p3_w;
  logic [7:0] pc_p1, pc_p2, pc_adv;
  logic       fetch_fault, adv_ok, ra, rb, tgt_ok, data_ok;
  logic [RIW-1:0] a_idx;

  logic       ex_ok, ex_rf_we, ex_zf_we, ex_pc_we, ex_halt, ex_load, ex_store;
  logic [7:0] ex_rf_wd, ex_pc_d;
  logic       ex_zf_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;

  assign in_acc     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign uc         = bics_pkg::uc_rom(step_q);
  assign deliver    = busy_q && uc.done && !(out_valid_q && out_stall_i);
  assign rdata      = vld_rd_q ? rd_q : 8'h00;

  // Checks against the effective program length
  assign len_eff     = (prog_len_q > MemLen) ? MemLen : prog_len_q;
  assign pc_p3_w     = {1'b0, pc_q} + 9'd3;
  assign pc_p1       = pc_q + 8'd1;
  assign pc_p2       = pc_q + 8'd2;
  assign pc_adv      = pc_q + 8'd3;
  assign fetch_fault = halt_q || (pc_p3_w > len_eff);
  assign adv_ok      = pc_p3_w < len_eff;
  assign ra          = {1'b0, a_q} < RegCnt;
  assign rb          = {1'b0, b_q} < RegCnt;
  assign tgt_ok      = ({1'b0, a_q} < len_eff) && bics_pkg::is_mult3(a_q);
  assign data_ok     = ({1'b0, b_q} < MemLen) && ({1'b0, b_q} >= len_eff);
  assign a_idx       = a_q[RIW-1:0];

  // Execute decode: one instruction's effect on state, from the latched bytes
  always_comb begin
    ex_ok    = 1'b0;
    ex_rf_we = 1'b0;
    ex_rf_wd = 8'h00;
    ex_zf_we = 1'b0;
    ex_zf_d  = 1'b0;
    ex_pc_we = 1'b0;
    ex_pc_d  = pc_adv;
    ex_halt  = 1'b0;
    ex_load  = 1'b0;
    ex_store = 1'b0;
    unique case (op_q)
      bics_pkg::OP_NOP: begin
        ex_ok    = adv_ok;
        ex_pc_we = adv_ok;
      end
      bics_pkg::OP_HALT: begin
        ex_ok   = 1'b1;
        ex_halt = 1'b1;
      end
      bics_pkg::OP_LOADI: begin
        if (ra) begin
          ex_rf_we = 1'b1;
          ex_rf_wd = b_q;
          ex_zf_we = 1'b1;
          ex_zf_d  = (b_q == 8'h00);
          ex_ok    = adv_ok;
          ex_pc_we = adv_ok;
        end
      end
      bics_pkg::OP_ADD, bics_pkg::OP_SUB: begin
        if (ra && rb) begin
          ex_rf_we = 1'b1;
          ex_rf_wd = (op_q == bics_pkg::OP_ADD) ? opa_q + opb_q : opa_q - opb_q;
          ex_zf_we = 1'b1;
          ex_zf_d  = (ex_rf_wd == 8'h00);
          ex_ok    = adv_ok;
          ex_pc_we = adv_ok;
        end
      end
      bics_pkg::OP_JMP: begin
        if (tgt_ok) begin
          ex_ok    = 1'b1;
          ex_pc_we = 1'b1;
          ex_pc_d  = a_q;
        end
      end
      bics_pkg::OP_JZ: begin
        if (tgt_ok) begin
          if (zf_q) begin
            ex_ok    = 1'b1;
            ex_pc_we = 1'b1;
            ex_pc_d  = a_q;
          end else begin
            ex_ok    = adv_ok;
            ex_pc_we = adv_ok;
          end
        end
      end
      bics_pkg::OP_LOAD: begin
        if (ra && data_ok) begin
          ex_load  = 1'b1;
          ex_ok    = adv_ok;
          ex_pc_we = adv_ok;
        end
      end
      bics_pkg::OP_STORE: begin
        if (ra && data_ok) begin
          ex_store = 1'b1;
          ex_ok    = adv_ok;
          ex_pc_we = adv_ok;
        end
      end
      bics_pkg::OP_CMP: begin
        if (ra && rb) begin
          ex_zf_we = 1'b1;
          ex_zf_d  = (opa_q == opb_q);
          ex_ok    = adv_ok;
          ex_pc_we = adv_ok;
        end
      end
      default: begin
        ex_ok = 1'b0;
      end
    endcase
  end

  // Single memory port: host writes when idle, microcode reads and stores when busy
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = address_i[AW-1:0];
    mem_wd   = write_data_i;
    if (in_acc) begin
      mem_we = (req_type_i == bics_pkg::REQ_WRITE) && ({1'b0, address_i} < MemLen);
    end else if (busy_q) begin
      unique case (uc.mem)
        bics_pkg::UM_PC0: begin
          mem_re   = 1'b1;
          mem_addr = pc_q[AW-1:0];
        end
        bics_pkg::UM_PC1: begin
          mem_re   = 1'b1;
          mem_addr = pc_p1[AW-1:0];
        end
        bics_pkg::UM_PC2: begin
          mem_re   = 1'b1;
          mem_addr = pc_p2[AW-1:0];
        end
        bics_pkg::UM_DATA: begin
          mem_re   = ex_load;
          mem_we   = ex_store;
          mem_addr = b_q[AW-1:0];
          mem_wd   = opa_q;
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end
  end

  // Conditional jump select
  always_comb begin
    unique case (uc.cond)
      bics_pkg::UJ_FETCH_FAULT: take_jump = fetch_fault;
      bics_pkg::UJ_NOT_LOAD:    take_jump = !ex_load;
      default:                  take_jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  // Valid bits: an entry never written since clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (in_acc && (req_type_i == bics_pkg::REQ_CLEAR)) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[mem_addr] <= 1'b1;
      end
      if (mem_re) begin
        vld_rd_q <= vld_q[mem_addr];
      end
    end
  end

  // Sequencer, architectural state and request status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
      busy_q     <= 1'b0;
      step_q     <= bics_pkg::UC_DONE;
      ok_q       <= 1'b0;
      pc_q       <= '0;
      zf_q       <= 1'b0;
      halt_q     <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        prog_len_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
        unique case (req_type_i)
          bics_pkg::REQ_CLEAR: begin
            step_q <= bics_pkg::UC_DONE;
            ok_q   <= 1'b1;
            pc_q   <= '0;
            zf_q   <= 1'b0;
            halt_q <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
              rf_q[i] <= '0;
            end
          end
          bics_pkg::REQ_WRITE: begin
            step_q <= bics_pkg::UC_DONE;
            ok_q   <= ({1'b0, address_i} < MemLen);
          end
          bics_pkg::REQ_EXEC: begin
            step_q <= bics_pkg::UC_FETCH0;
            ok_q   <= 1'b0;
          end
          default: begin
            step_q <= bics_pkg::UC_DONE;
            ok_q   <= 1'b0;
          end
        endcase
      end else if (busy_q) begin
        if (uc.exec) begin
          ok_q <= ex_ok;
          if (ex_rf_we) rf_q[a_idx] <= ex_rf_wd;
          if (ex_zf_we) zf_q <= ex_zf_d;
          if (ex_pc_we) pc_q <= ex_pc_d;
          if (ex_halt)  halt_q <= 1'b1;
        end
        if (uc.ldwb) begin
          rf_q[a_idx] <= rdata;
        end
        // Hold in the delivery step until the output register frees up
        if (uc.done) begin
          if (deliver) busy_q <= 1'b0;
        end else begin
          step_q <= take_jump ? uc.jump : uc.next;
        end
      end
    end
  end

  // Instruction byte latches and operand reads
  always_ff @(posedge clk_i) begin
    if (busy_q && uc.lat_op) op_q <= rdata;
    if (busy_q && uc.lat_a)  a_q  <= rdata;
    if (busy_q && uc.lat_b) begin
      b_q   <= rdata;
      opa_q <= rf_q[a_idx];
      opb_q <= rf_q[rdata[RIW-1:0]];
    end
  end

  // Registers beyond the configured count read as zero
  for (genvar j = 0; j < 4; j++) begin : g_view
    if (j < REGISTER_COUNT) begin : g_reg
      assign rf_view[j] = rf_q[j];
    end else begin : g_none
      assign rf_view[j] = 8'h00;
    end
  end

  // Output register: capture the state snapshot on delivery, drop on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (deliver) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      out_ok_q   <= ok_q;
      out_halt_q <= halt_q;
      out_pc_q   <= pc_q;
      out_zf_q   <= zf_q;
      for (int j = 0; j < 4; j++) begin
        out_rf_q[j] <= rf_view[j];
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign halted_now_o      = out_halt_q;
  assign program_counter_o = out_pc_q;
  assign zero_flag_out_o   = out_zf_q;
  assign reg0_value_o      = out_rf_q[0];
  assign reg1_value_o      = out_rf_q[1];
  assign reg2_value_o      = out_rf_q[2];
  assign reg3_value_o      = out_rf_q[3];

endmodule

>>> verif/tb_byte_isa_cpu_step_core.sv
// Testbench for the byte ISA CPU step core: random programs checked against a state mirror.
`timescale 1ns / 1ps

module tb_byte_isa_cpu_step_core;

  localparam int REG_N = bics_pkg::RegisterCountDefault;
  localparam int MEM_N = bics_pkg::MemoryBytesDefault;
  localparam logic [1:0] REQ_UNUSED = 2'd3;   // reserved request type, must be rejected
  localparam int ITEM_GOAL = 1400;
  localparam int IDLE_LIMIT = 3000;           // cycles with no handshake before giving up
  localparam int MAX_REPORTS = 10;

  // One result as it leaves the block.
  typedef struct packed {
    logic       ok;
    logic       halted;
    logic [7:0] pc;
    logic       zf;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
    logic [7:0] r3;
  } cpu_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_mode_e;

  // Mirror of the machine state; every accepted request advances it and queues the
  // state the block must report for that request.
  class cpu_state_mirror;
    logic [7:0]  regs [REG_N];
    logic [7:0]  mem [MEM_N];
    logic [7:0]  pc;
    bit          zf;
    bit          halted;
    logic [8:0]  prog_len;
    cpu_result_t expected_states[$];
    int          fail_count;

    function new();
      wipe();
      prog_len = '0;
      fail_count = 0;
    endfunction

    function void wipe();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      zf = 1'b0;
      halted = 1'b0;
    endfunction

    function void write_length(logic [8:0] len);
      prog_len = len;
    endfunction

    // Program length as the block uses it: saturated to the memory size.
    function int unsigned effective_length();
      return (prog_len > MEM_N) ? MEM_N : prog_len;
    endfunction

    function bit advance();
      int unsigned next_pc;
      next_pc = pc + 3;
      if (next_pc >= effective_length()) return 1'b0;
      pc = next_pc[7:0];
      return 1'b1;
    endfunction

    function bit target_ok(logic [7:0] t);
      return (t < effective_length()) && (t % 3 == 0);
    endfunction

    function bit data_ok(logic [7:0] addr);
      return (addr < MEM_N) && (addr >= effective_length());
    endfunction

    function bit run_instruction();
      logic [7:0] op;
      logic [7:0] a;
      logic [7:0] b;
      bit ra;
      bit rb;
      if (halted) return 1'b0;
      if (pc + 3 > effective_length()) return 1'b0;
      op = mem[pc];
      a = mem[8'(pc + 8'd1)];
      b = mem[8'(pc + 8'd2)];
      ra = a < REG_N;
      rb = b < REG_N;
      case (op)
        bics_pkg::OP_NOP: return advance();
        bics_pkg::OP_HALT: begin
          halted = 1'b1;
          return 1'b1;
        end
        bics_pkg::OP_LOADI: begin
          if (!ra) return 1'b0;
          regs[a] = b;
          zf = (b == 8'd0);
          return advance();
        end
        bics_pkg::OP_ADD: begin
          if (!ra || !rb) return 1'b0;
          regs[a] = regs[a] + regs[b];
          zf = (regs[a] == 8'd0);
          return advance();
        end
        bics_pkg::OP_SUB: begin
          if (!ra || !rb) return 1'b0;
          regs[a] = regs[a] - regs[b];
          zf = (regs[a] == 8'd0);
          return advance();
        end
        bics_pkg::OP_JMP: begin
          if (!target_ok(a)) return 1'b0;
          pc = a;
          return 1'b1;
        end
        bics_pkg::OP_JZ: begin
          // the target is checked even when the branch is not taken
          if (!target_ok(a)) return 1'b0;
          if (zf) begin
            pc = a;
            return 1'b1;
          end
          return advance();
        end
        bics_pkg::OP_LOAD: begin
          if (!ra || !data_ok(b)) return 1'b0;
          regs[a] = mem[b];
          return advance();
        end
        bics_pkg::OP_STORE: begin
          if (!ra || !data_ok(b)) return 1'b0;
          mem[b] = regs[a];
          return advance();
        end
        bics_pkg::OP_CMP: begin
          if (!ra || !rb) return 1'b0;
          zf = (regs[a] == regs[b]);
          return advance();
        end
        default: return 1'b0;
      endcase
    endfunction

    function void apply_request(logic [1:0] kind, logic [7:0] addr, logic [7:0] data);
      cpu_result_t r;
      bit ok;
      ok = 1'b0;
      case (kind)
        bics_pkg::REQ_CLEAR: begin
          wipe();
          ok = 1'b1;
        end
        bics_pkg::REQ_WRITE: begin
          mem[addr] = data;
          ok = 1'b1;
        end
        bics_pkg::REQ_EXEC: ok = run_instruction();
        default: ok = 1'b0;
      endcase
      r.ok = ok;
      r.halted = halted;
      r.pc = pc;
      r.zf = zf;
      r.r0 = regs[0];
      r.r1 = regs[1];
      r.r2 = regs[2];
      r.r3 = regs[3];
      expected_states.push_back(r);
    endfunction

    function void check_result(cpu_result_t got);
      cpu_result_t want;
      if (expected_states.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] result with no request pending: ok=%0d pc=%0d", $realtime,
                   got.ok, got.pc);
        return;
      end
      want = expected_states.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("[%0t] mismatch expected ok=%0d halt=%0d pc=%0d z=%0d r=%h %h %h %h",
                   $realtime, want.ok, want.halted, want.pc, want.zf,
                   want.r0, want.r1, want.r2, want.r3);
          $display("[%0t]            actual ok=%0d halt=%0d pc=%0d z=%0d r=%h %h %h %h",
                   $realtime, got.ok, got.halted, got.pc, got.zf,
                   got.r0, got.r1, got.r2, got.r3);
        end
      end
    endfunction

    function int pending();
      return expected_states.size();
    endfunction

    function bit is_halted();
      return halted;
    endfunction

    function int failures();
      return fail_count;
    endfunction
  endclass

  // Clock, reset and every block input start at a known value.
  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic [1:0] req_type = '0;
  logic [7:0] address = '0;
  logic [7:0] write_data = '0;
  logic       out_stall = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic       ok_o;
  logic       halted_now_o;
  logic [7:0] program_counter_o;
  logic       zero_flag_out_o;
  logic [7:0] reg0_value_o;
  logic [7:0] reg1_value_o;
  logic [7:0] reg2_value_o;
  logic [7:0] reg3_value_o;

  cpu_state_mirror mirror = new();

  int          sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  byte_isa_cpu_step_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type),
    .address_i        (address),
    .write_data_i     (write_data),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .ok_o             (ok_o),
    .halted_now_o     (halted_now_o),
    .program_counter_o(program_counter_o),
    .zero_flag_out_o  (zero_flag_out_o),
    .reg0_value_o     (reg0_value_o),
    .reg1_value_o     (reg1_value_o),
    .reg2_value_o     (reg2_value_o),
    .reg3_value_o     (reg3_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: pick a stall mode for a stretch of cycles, then drive stall from it.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_left / 4) % 2) == 1;
    endcase
  end

  // Sample results at the rising edge and check them in order.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall)
      mirror.check_result('{ok: ok_o, halted: halted_now_o, pc: program_counter_o,
                            zf: zero_flag_out_o, r0: reg0_value_o, r1: reg1_value_o,
                            r2: reg2_value_o, r3: reg3_value_o});
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one request and hold it until accepted; insert a random gap between bursts.
  task automatic send_request(input logic [1:0] kind, input logic [7:0] addr,
                              input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid   <= 1'b1;
    req_type   <= kind;
    address    <= addr;
    write_data <= data;
    do @(posedge clk_i); while (in_stall_o);
    mirror.apply_request(kind, addr, data);
    sent++;
  endtask

  // Drop valid at once so a held request is never taken twice.
  task automatic drop_request();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Change the program length only with the block drained.
  task automatic set_program_length(input logic [8:0] len);
    drop_request();
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk_i);
    mirror.write_length(len);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_insn(input logic [7:0] at, input logic [7:0] op,
                            input logic [7:0] a, input logic [7:0] b);
    send_request(bics_pkg::REQ_WRITE, at, op);
    send_request(bics_pkg::REQ_WRITE, 8'(at + 8'd1), a);
    send_request(bics_pkg::REQ_WRITE, 8'(at + 8'd2), b);
  endtask

  // Mostly a legal register, now and then any byte.
  function automatic logic [7:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, REG_N - 1));
  endfunction

  function automatic logic [7:0] pick_target(input int unsigned len);
    if (len >= 3 && $urandom_range(0, 7) != 0)
      return 8'(3 * $urandom_range(0, (len - 1) / 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_data_addr(input int unsigned len);
    if (len < MEM_N && $urandom_range(0, 7) != 0)
      return 8'($urandom_range(len, MEM_N - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Write one random, mostly well-formed instruction at the given slot.
  task automatic write_random_insn(input logic [7:0] at, input int unsigned len);
    logic [7:0] op;
    logic [7:0] a;
    logic [7:0] b;
    if ($urandom_range(0, 99) < 4) begin
      op = 8'($urandom_range(10, 255));
    end else begin
      op = 8'($urandom_range(0, 9));
      // keep HALT rare so programs run for a while
      if (op == bics_pkg::OP_HALT && $urandom_range(0, 3) != 0) op = bics_pkg::OP_NOP;
    end
    a = pick_reg();
    b = pick_reg();
    case (op)
      bics_pkg::OP_LOADI: b = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      bics_pkg::OP_JMP, bics_pkg::OP_JZ: begin
        a = pick_target(len);
        b = 8'($urandom_range(0, 255));
      end
      bics_pkg::OP_LOAD, bics_pkg::OP_STORE: b = pick_data_addr(len);
      default: ;
    endcase
    write_insn(at, op, a, b);
  endtask

  initial begin
    int unsigned len;
    int          n_insn;
    int          steps;
    int          phase;
    int          pick;
    logic [8:0]  cfg_len;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed: fetch with no program, reserved request, extreme write values.
    send_request(bics_pkg::REQ_EXEC, 8'd0, 8'd0);
    send_request(REQ_UNUSED, 8'hFF, 8'hFF);
    send_request(bics_pkg::REQ_WRITE, 8'hFF, 8'hFF);

    // Small program: load, store, compare, taken branch back, then halt.
    set_program_length(9'd12);
    send_request(bics_pkg::REQ_CLEAR, 8'd0, 8'd0);
    write_insn(8'd0, bics_pkg::OP_LOADI, 8'd3, 8'hFF);
    write_insn(8'd3, bics_pkg::OP_STORE, 8'd3, 8'd200);
    write_insn(8'd6, bics_pkg::OP_CMP, 8'd0, 8'd0);
    write_insn(8'd9, bics_pkg::OP_JZ, 8'd0, 8'd0);
    repeat (5) send_request(bics_pkg::REQ_EXEC, 8'd0, 8'd0);
    send_request(bics_pkg::REQ_WRITE, 8'd3, bics_pkg::OP_HALT);
    send_request(bics_pkg::REQ_EXEC, 8'd0, 8'd0);
    send_request(bics_pkg::REQ_EXEC, 8'd0, 8'd0);

    // Random phases: new length, clear, load a program, then run it with some noise.
    phase = 0;
    while (sent < ITEM_GOAL) begin
      pick = (phase < 3) ? phase : $urandom_range(0, 15);
      case (pick)
        0:       cfg_len = 9'd0;
        1:       cfg_len = 9'd511;
        2:       cfg_len = 9'd256;
        3:       cfg_len = 9'($urandom_range(257, 510));
        4:       cfg_len = 9'($urandom_range(1, 255));
        default: cfg_len = 9'(3 * $urandom_range(1, 12) +
                              (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
      endcase
      phase++;
      set_program_length(cfg_len);
      send_request(bics_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      len = mirror.effective_length();
      n_insn = (len / 3 > 16) ? 16 : len / 3;
      for (int i = 0; i < n_insn; i++) write_random_insn(8'(3 * i), len);
      // seed the data area
      if (len < MEM_N) begin
        repeat ($urandom_range(0, 4))
          send_request(bics_pkg::REQ_WRITE, 8'($urandom_range(len, MEM_N - 1)),
                       8'($urandom_range(0, 255)));
      end
      steps = $urandom_range(8, 40);
      for (int s = 0; s < steps; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6)
          send_request(bics_pkg::REQ_WRITE, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        else if (pick < 9)
          send_request(REQ_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
          send_request(bics_pkg::REQ_EXEC, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        // leave a halted machine after a few refused executes
        if (mirror.is_halted() && $urandom_range(0, 3) == 0) break;
      end
    end

    // Drain: wait for every result, then wait on for stray output.
    drop_request();
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mirror.failures() == 0 && mirror.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
